@@ hw/rtl/b58d_pkg.sv @@
`default_nettype none
package b58d_pkg;

  localparam int unsigned BufBytesDef = 40;
  localparam int unsigned MaxCharsDef = 54;
  localparam int unsigned ResultLimit = 64;
  localparam int unsigned Radix       = 58;
  localparam int unsigned CntW        = 7;
  localparam int unsigned CarryW      = 6;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadChar  = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OpHold,
    OpMac,
    OpShiftOut,
    OpClear
  } buf_op_e;

  typedef struct packed {
    buf_op_e               op;
    logic                  first;
    logic [CarryW-1:0]     digit;
  } buf_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [CarryW-1:0] digit;
  } digit_t;

  function automatic digit_t digit_of(logic [7:0] ch);
    digit_t     d;
    logic [7:0] v;
    d.valid = 1'b1;
    v       = '0;
    priority if (ch >= "1" && ch <= "9") begin
      v = ch - "1";
    end else if (ch >= "A" && ch <= "H") begin
      v = ch - "A" + 8'd9;
    end else if (ch >= "J" && ch <= "N") begin
      v = ch - "J" + 8'd17;
    end else if (ch >= "P" && ch <= "Z") begin
      v = ch - "P" + 8'd22;
    end else if (ch >= "a" && ch <= "k") begin
      v = ch - "a" + 8'd33;
    end else if (ch >= "m" && ch <= "z") begin
      v = ch - "m" + 8'd44;
    end else begin
      d.valid = 1'b0;
    end
    d.digit = v[CarryW-1:0];
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/base58_decoder.sv @@
// Base58 decoder, standard Bitcoin alphabet, one character per transfer.
// Input: drive symbol_i and last_symbol_i with start; the character is taken
// on a rising edge with start high and busy low. A valid character that is
// not under a held error and within MAX_CHARS keeps busy high through its
// multiply pass and a check state: the buffer is a byte shift register and
// one 8x6 multiply-by-58 step runs per cycle, over every byte in turn.
// Invalid characters, and characters after an error, get no multiply pass.
// Output: each result is shown for one cycle with strobe_o high; there is
// no backpressure. After the last character's multiply pass and the check
// state, the leading zero bytes come one per cycle, then shifts without a
// strobe drop the high zero bytes, then the n significant bytes come one
// per cycle, most significant first.
// final_byte_o marks the last transfer. An error is held until the last
// character, then gives a single transfer with data 0, final 1 and status
// set, in the cycle right after it is taken (or after its check state).
// Reset clears the buffer and all counters at once; the block is ready in
// the first cycle after reset is released.
`default_nettype none
module base58_decoder #(
  parameter int unsigned BUF_BYTES = b58d_pkg::BufBytesDef,
  parameter int unsigned MAX_CHARS = b58d_pkg::MaxCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] symbol_i,
  input  logic       last_symbol_i,
  output logic       strobe_o,
  output logic [7:0] data_byte_o,
  output logic       final_byte_o,
  output logic [1:0] status_o
);
  import b58d_pkg::*;

  localparam int unsigned SigW = $clog2(BUF_BYTES + 1);

  buf_cmd_t          cmd;
  logic [7:0]        head;
  logic [CarryW-1:0] carry;
  logic [SigW-1:0]   sig_len;

  b58d_ctrl #(
    .BUF_BYTES(BUF_BYTES),
    .MAX_CHARS(MAX_CHARS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .cmd_o        (cmd),
    .head_i       (head),
    .carry_i      (carry),
    .sig_len_i    (sig_len),
    .strobe_o     (strobe_o),
    .data_byte_o  (data_byte_o),
    .final_byte_o (final_byte_o),
    .status_o     (status_o)
  );

  b58d_mac_buffer #(
    .BUF_BYTES(BUF_BYTES)
  ) u_buffer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .head_o   (head),
    .carry_o  (carry),
    .sig_len_o(sig_len)
  );

endmodule
`default_nettype wire

@@ hw/rtl/b58d_mac_buffer.sv @@
`default_nettype none
module b58d_mac_buffer #(
  parameter  int unsigned BUF_BYTES = b58d_pkg::BufBytesDef,
  localparam int unsigned SigW      = $clog2(BUF_BYTES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  b58d_pkg::buf_cmd_t            cmd_i,
  output logic [7:0]                    head_o,
  output logic [b58d_pkg::CarryW-1:0]   carry_o,
  output logic [SigW-1:0]               sig_len_o
);
  import b58d_pkg::*;

  localparam int unsigned AccW = 8 + CarryW;

  logic [7:0]        val_q [BUF_BYTES];
  logic [7:0]        val_d [BUF_BYTES];
  logic [CarryW-1:0] carry_q, carry_d, carry_in;
  logic [AccW-1:0]   acc;
  logic [SigW-1:0]   pos_q, pos_d, sig_q, sig_d;

  assign carry_in = cmd_i.first ? cmd_i.digit : carry_q;
  assign acc      = AccW'(val_q[BUF_BYTES-1]) * AccW'(Radix) + AccW'(carry_in);

  always_comb begin
    val_d   = val_q;
    carry_d = carry_q;
    pos_d   = pos_q;
    sig_d   = sig_q;
    unique case (cmd_i.op)
      OpHold: begin
      end
      OpMac: begin
        val_d[0] = acc[7:0];
        for (int i = 1; i < BUF_BYTES; i++) begin
          val_d[i] = val_q[i-1];
        end
        carry_d = acc[AccW-1:8];
        pos_d   = cmd_i.first ? SigW'(1) : pos_q + SigW'(1);
        if (acc[7:0] != 8'd0) begin
          sig_d = pos_d;
        end else if (cmd_i.first) begin
          sig_d = '0;
        end
      end
      OpShiftOut: begin
        for (int i = 0; i < BUF_BYTES - 1; i++) begin
          val_d[i] = val_q[i+1];
        end
        val_d[BUF_BYTES-1] = '0;
      end
      OpClear: begin
        for (int i = 0; i < BUF_BYTES; i++) begin
          val_d[i] = '0;
        end
        carry_d = '0;
        pos_d   = '0;
        sig_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '{default: '0};
      carry_q <= '0;
      pos_q   <= '0;
      sig_q   <= '0;
    end else begin
      val_q   <= val_d;
      carry_q <= carry_d;
      pos_q   <= pos_d;
      sig_q   <= sig_d;
    end
  end

  assign head_o    = val_q[0];
  assign carry_o   = carry_q;
  assign sig_len_o = sig_q;

  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op) == OpMac |-> carry_q < CarryW'(Radix))
    else $error("carry out of range after multiply step");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpClear |=> sig_q == '0 && val_q[0] == '0 && val_q[BUF_BYTES-1] == '0)
    else $error("buffer not cleared");

endmodule
`default_nettype wire

@@ hw/rtl/b58d_ctrl.sv @@
`default_nettype none
module b58d_ctrl #(
  parameter  int unsigned BUF_BYTES = b58d_pkg::BufBytesDef,
  parameter  int unsigned MAX_CHARS = b58d_pkg::MaxCharsDef,
  localparam int unsigned SigW      = $clog2(BUF_BYTES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    symbol_i,
  input  logic                          last_symbol_i,
  output b58d_pkg::buf_cmd_t            cmd_o,
  input  logic [7:0]                    head_i,
  input  logic [b58d_pkg::CarryW-1:0]   carry_i,
  input  logic [SigW-1:0]               sig_len_i,
  output logic                          strobe_o,
  output logic [7:0]                    data_byte_o,
  output logic                          final_byte_o,
  output logic [1:0]                    status_o
);
  import b58d_pkg::*;

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SMac   = 7'b0000010,
    SCheck = 7'b0000100,
    SLead  = 7'b0001000,
    SSkip  = 7'b0010000,
    SOut   = 7'b0100000,
    SErr   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CarryW-1:0] digit_q, digit_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   sym_cnt_q, sym_cnt_d;
  logic [CntW-1:0]   lead_q, lead_d;
  logic              in_run_q, in_run_d;
  status_e           err_q, err_d;
  logic [SigW-1:0]   cnt_q, cnt_d;
  digit_t            dig;
  logic [CntW:0]     total;
  logic              done;
  status_e           status;

  assign dig   = digit_of(symbol_i);
  assign total = (CntW+1)'(lead_q) + (CntW+1)'(sig_len_i);

  always_comb begin
    state_d      = state_q;
    digit_d      = digit_q;
    last_d       = last_q;
    sym_cnt_d    = sym_cnt_q;
    lead_d       = lead_q;
    in_run_d     = in_run_q;
    err_d        = err_q;
    cnt_d        = cnt_q;
    cmd_o        = '{op: OpHold, first: 1'b0, digit: digit_q};
    strobe_o     = 1'b0;
    data_byte_o  = '0;
    final_byte_o = 1'b0;
    status       = StatusOk;
    done         = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          last_d = last_symbol_i;
          priority if (err_q != StatusOk) begin
          end else if (!dig.valid) begin
            err_d = StatusBadChar;
          end else if (sym_cnt_q >= CntW'(MAX_CHARS)) begin
            err_d = StatusOverflow;
          end else begin
            sym_cnt_d = sym_cnt_q + CntW'(1);
            if (in_run_q && symbol_i == "1") begin
              lead_d = lead_q + CntW'(1);
            end else begin
              in_run_d = 1'b0;
            end
            digit_d = dig.digit;
            cnt_d   = '0;
            state_d = SMac;
          end
          if (state_d == SIdle && last_symbol_i) begin
            state_d = SErr;
          end
        end
      end
      SMac: begin
        cmd_o.op    = OpMac;
        cmd_o.first = (cnt_q == '0);
        cnt_d       = cnt_q + SigW'(1);
        if (cnt_q == SigW'(BUF_BYTES - 1)) begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        cnt_d = '0;
        priority if (carry_i != '0) begin
          err_d   = StatusOverflow;
          state_d = last_q ? SErr : SIdle;
        end else if (!last_q) begin
          state_d = SIdle;
        end else if (total > (CntW+1)'(ResultLimit)) begin
          err_d   = StatusOverflow;
          state_d = SErr;
        end else if (lead_q != '0) begin
          state_d = SLead;
        end else if (sig_len_i != '0) begin
          state_d = SSkip;
        end else begin
          done = 1'b1;
        end
      end
      SLead: begin
        strobe_o = 1'b1;
        lead_d   = lead_q - CntW'(1);
        if (lead_q == CntW'(1)) begin
          if (sig_len_i == '0) begin
            final_byte_o = 1'b1;
            done         = 1'b1;
          end else begin
            state_d = SSkip;
          end
        end
      end
      SSkip: begin
        if ((SigW+1)'(cnt_q) + (SigW+1)'(sig_len_i) == (SigW+1)'(BUF_BYTES)) begin
          cnt_d   = '0;
          state_d = SOut;
        end else begin
          cmd_o.op = OpShiftOut;
          cnt_d    = cnt_q + SigW'(1);
        end
      end
      SOut: begin
        strobe_o    = 1'b1;
        data_byte_o = head_i;
        cmd_o.op    = OpShiftOut;
        cnt_d       = cnt_q + SigW'(1);
        if (cnt_q + SigW'(1) == sig_len_i) begin
          final_byte_o = 1'b1;
          done         = 1'b1;
        end
      end
      SErr: begin
        strobe_o     = 1'b1;
        final_byte_o = 1'b1;
        status       = err_q;
        done         = 1'b1;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (done) begin
      state_d   = SIdle;
      sym_cnt_d = '0;
      lead_d    = '0;
      in_run_d  = 1'b1;
      err_d     = StatusOk;
      cnt_d     = '0;
      cmd_o.op  = OpClear;
    end
  end

  assign status_o = status;
  assign busy     = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      last_q    <= 1'b0;
      sym_cnt_q <= '0;
      lead_q    <= '0;
      in_run_q  <= 1'b1;
      err_q     <= StatusOk;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      sym_cnt_q <= sym_cnt_d;
      lead_q    <= lead_d;
      in_run_q  <= in_run_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  a_end_of_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && final_byte_o |=> state_q == SIdle && err_q == StatusOk
                                 && sym_cnt_q == '0 && lead_q == '0 && in_run_q)
    else $error("state not restored after final transfer");

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SOut && $past(state_q) == SSkip |-> head_i != 8'd0)
    else $error("first buffer byte sent is zero");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != StatusOk |-> final_byte_o && data_byte_o == 8'd0
                                         && $past(state_q) != SLead)
    else $error("error transfer malformed");

endmodule
`default_nettype wire
